// ----- rtl/core/indexed_insert_remove_list_assert.svh -----
`ifndef INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define IIRL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iirl check failed");

// next-cycle implication, sampled on clk, off during reset
`define IIRL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iirl check failed");

`endif

// ----- rtl/core/iirl_pkg.sv -----
package iirl_pkg;

	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;

	// fixed field widths of the ports
	localparam int POS_BITS  = 5;
	localparam int LEN_BITS  = 5;
	localparam int DATA_BITS = 32;

	localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// command broadcast to every cell in the row
	typedef struct packed {
		logic                 ins_en;
		logic                 rem_en;
		logic [CMP_BITS-1:0]  pos;
		logic [WORD_BITS-1:0] word;
	} cell_cmd_t;

	function automatic logic [WORD_BITS-1:0] narrow_word(input logic signed [DATA_BITS-1:0] w);
		logic signed [63:0] t;
		t = 64'(w);
		return t[WORD_BITS-1:0];
	endfunction

	function automatic logic signed [DATA_BITS-1:0] widen_word(input logic [WORD_BITS-1:0] w);
		logic signed [63:0] t;
		t = 64'(signed'(w));
		return t[DATA_BITS-1:0];
	endfunction

endpackage

// ----- rtl/core/iirl_cell.sv -----
module iirl_cell (
	input  logic                            clk,
	input  logic [iirl_pkg::IDX_BITS-1:0]   index,
	input  iirl_pkg::cell_cmd_t             cmd,
	input  logic [iirl_pkg::WORD_BITS-1:0]  left_word,
	input  logic [iirl_pkg::WORD_BITS-1:0]  right_word,
	output logic [iirl_pkg::WORD_BITS-1:0]  word
);

	logic [iirl_pkg::WORD_BITS-1:0] entry_q;
	logic [iirl_pkg::CMP_BITS-1:0]  idx_c;

	assign idx_c = iirl_pkg::CMP_BITS'(index);
	assign word  = entry_q;

	// insert: cells above the slot take the lower neighbor, the slot takes the new word
	// remove: cells from the slot up take the upper neighbor
	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (idx_c > cmd.pos) begin
				entry_q <= left_word;
			end else if (idx_c == cmd.pos) begin
				entry_q <= cmd.word;
			end
		end else if (cmd.rem_en) begin
			if (idx_c >= cmd.pos) begin
				entry_q <= right_word;
			end
		end
	end

endmodule

// ----- rtl/core/indexed_insert_remove_list.sv -----
// Ordered list of signed words held in a row of shift cells.
// Result: registered at the input transfer, valid in the following cycle.
// Throughput: one operation per cycle unless out_ready stalls; moving cells
// shift in the same cycle, and a read selects the addressed cell through one mux.
// Reset: entry count and output valid clear at once; cell contents stay
// undefined until inserted.
module indexed_insert_remove_list (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           kind,
	input  logic [iirl_pkg::POS_BITS-1:0]        position,
	input  logic signed [iirl_pkg::DATA_BITS-1:0] data_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           status,
	output logic [iirl_pkg::LEN_BITS-1:0]        length,
	output logic signed [iirl_pkg::DATA_BITS-1:0] read_word
);

	logic [iirl_pkg::WORD_BITS-1:0] cell_word [iirl_pkg::CAPACITY];
	iirl_pkg::cell_cmd_t            cmd;

	logic [iirl_pkg::CNT_BITS-1:0]  count_q;
	logic [iirl_pkg::CNT_BITS-1:0]  count_next;
	logic                           out_valid_q;
	logic [1:0]                     status_q;
	logic [iirl_pkg::LEN_BITS-1:0]  length_q;
	logic signed [iirl_pkg::DATA_BITS-1:0] read_word_q;

	logic                           accept;
	iirl_pkg::kind_t                kind_c;
	iirl_pkg::status_t              status_c;
	logic                           ins_ok;
	logic                           rem_ok;
	logic                           clr;
	logic signed [iirl_pkg::DATA_BITS-1:0] rd_c;
	logic [iirl_pkg::CMP_BITS-1:0]  pos_c;
	logic [iirl_pkg::CMP_BITS-1:0]  cnt_c;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign kind_c   = iirl_pkg::kind_t'(kind);
	assign pos_c    = iirl_pkg::CMP_BITS'(position);
	assign cnt_c    = iirl_pkg::CMP_BITS'(count_q);

	always_comb begin
		status_c = iirl_pkg::ST_OK;
		ins_ok   = 1'b0;
		rem_ok   = 1'b0;
		clr      = 1'b0;
		rd_c     = '0;
		case (kind_c)
			iirl_pkg::KIND_INSERT: begin
				if (pos_c > cnt_c) begin
					status_c = iirl_pkg::ST_BAD_POS;
				end else if (count_q == iirl_pkg::CNT_BITS'(iirl_pkg::CAPACITY)) begin
					status_c = iirl_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			iirl_pkg::KIND_REMOVE: begin
				if (pos_c >= cnt_c) begin
					status_c = iirl_pkg::ST_BAD_POS;
				end else begin
					rem_ok = 1'b1;
				end
			end
			iirl_pkg::KIND_CLEAR: begin
				clr = 1'b1;
			end
			iirl_pkg::KIND_READ: begin
				if (pos_c >= cnt_c) begin
					status_c = iirl_pkg::ST_BAD_POS;
				end else begin
					// pos below count, so it fits the cell index
					rd_c = iirl_pkg::widen_word(cell_word[pos_c[iirl_pkg::IDX_BITS-1:0]]);
				end
			end
			default: begin
				status_c = iirl_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + 1'b1;
		end else if (rem_ok) begin
			count_next = count_q - 1'b1;
		end else if (clr) begin
			count_next = '0;
		end
	end

	assign cmd.ins_en = accept && ins_ok;
	assign cmd.rem_en = accept && rem_ok;
	assign cmd.pos    = pos_c;
	assign cmd.word   = iirl_pkg::narrow_word(data_word);

	for (genvar g = 0; g < iirl_pkg::CAPACITY; g++) begin : g_cell
		logic [iirl_pkg::WORD_BITS-1:0] left_w;
		logic [iirl_pkg::WORD_BITS-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[g-1];
		end

		if (g == iirl_pkg::CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[g+1];
		end

		iirl_cell u_cell (
			.clk        (clk),
			.index      (iirl_pkg::IDX_BITS'(g)),
			.cmd        (cmd),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_c;
			length_q    <= iirl_pkg::LEN_BITS'(count_next);
			read_word_q <= rd_c;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign length    = length_q;
	assign read_word = read_word_q;

endmodule

// ----- rtl/core/iirl_checker.sv -----
`include "indexed_insert_remove_list_assert.svh"

module iirl_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic [1:0]                           kind,
	input logic [iirl_pkg::POS_BITS-1:0]        position,
	input logic signed [iirl_pkg::DATA_BITS-1:0] data_word,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [1:0]                           status,
	input logic [iirl_pkg::LEN_BITS-1:0]        length,
	input logic signed [iirl_pkg::DATA_BITS-1:0] read_word
);

	// stalled result holds
	`IIRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(length) && $stable(read_word))

	// clear transfer shows an empty list on the next result
	`IIRL_ASSERT_NEXT(a_clear_empty, in_valid && in_ready && (kind == iirl_pkg::KIND_CLEAR), out_valid && (length == '0) && (status == iirl_pkg::ST_OK))

	// rejected operations never return data
	`IIRL_ASSERT_NOW(a_reject_zero, out_valid && (status != iirl_pkg::ST_OK), read_word == '0)

	// full is only reported at capacity
	`IIRL_ASSERT_NOW(a_full_len, out_valid && (status == iirl_pkg::ST_FULL), length == iirl_pkg::LEN_BITS'(iirl_pkg::CAPACITY))

endmodule

bind indexed_insert_remove_list iirl_checker u_iirl_checker (.*);
